// File: sv/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OCC_W   = 11;
  localparam int unsigned GROUP_N = 32;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_PUSH_FRONT = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_POP_FRONT  = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_SHIFT_UP   = 2'd1,
    CELL_SHIFT_DOWN = 2'd2,
    CELL_LOAD_BACK  = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_GATHER = 2'd1,
    S_REPORT = 2'd2
  } state_e;

  typedef struct packed {
    cell_op_e            op;
    logic [WORD_W-1:0]   value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]          action;
    logic signed [31:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  front_value;
    logic signed [31:0]  back_value;
    logic                is_empty;
    logic [OCC_W-1:0]    occupancy;
    logic [1:0]          status;
  } out_t;

endpackage

// File: sv/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 11
) (
  input  logic                          clk_i,
  input  deq_pkg::cell_ctrl_t           ctrl_i,
  input  logic [CNT_W-1:0]              count_i,
  input  logic [deq_pkg::WORD_W-1:0]    prev_i,
  input  logic [deq_pkg::WORD_W-1:0]    next_i,
  output logic [deq_pkg::WORD_W-1:0]    data_o,
  output logic [deq_pkg::WORD_W-1:0]    back_o
);

  logic [deq_pkg::WORD_W-1:0] data_q;
  logic [deq_pkg::WORD_W-1:0] data_d;

  // take from a neighbor on a shift, or the pushed value when this is the first free cell
  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      deq_pkg::CELL_HOLD:       data_d = data_q;
      deq_pkg::CELL_SHIFT_UP:   data_d = prev_i;
      deq_pkg::CELL_SHIFT_DOWN: data_d = next_i;
      deq_pkg::CELL_LOAD_BACK: begin
        if (count_i == CNT_W'(INDEX)) begin
          data_d = ctrl_i.value;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // present data only when this cell holds the back element
  assign back_o = (count_i == CNT_W'(INDEX + 1)) ? data_q : '0;

endmodule

// File: sv/deq_or_reduce.sv
`timescale 1ns / 1ps

module deq_or_reduce #(
  parameter int unsigned N = 32
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [N-1:0][deq_pkg::WORD_W-1:0]    leaves_i,
  output logic [deq_pkg::WORD_W-1:0]           sum_o
);

  logic [deq_pkg::WORD_W-1:0] sum_q;
  logic [deq_pkg::WORD_W-1:0] sum_d;

  // merge the leaves; at most one is nonzero
  always_comb begin
    sum_d = '0;
    for (int unsigned k = 0; k < N; k++) begin
      sum_d = sum_d | leaves_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: sv/double_ended_queue.sv
`timescale 1ns / 1ps
// An accepted input passes through the gather and report states before its result is valid;
// a new input is taken only back in the idle state. The back element is found through a
// two-level registered OR tree over the cell row, which sets this sequence.
// Reset clears the element count, status, handshake state and result valid.
// Cell contents are not cleared; a cell is only read while it holds an element.
module double_ended_queue #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  deq_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output deq_pkg::out_t   out_data_o
);

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned GROUP  = deq_pkg::GROUP_N;
  localparam int unsigned NGROUP = (DEPTH + GROUP - 1) / GROUP;
  localparam int unsigned W      = deq_pkg::WORD_W;

  deq_pkg::state_e     state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  deq_pkg::status_e    status_q, status_d;
  logic                out_valid_q, out_valid_d;
  deq_pkg::out_t       out_q;
  deq_pkg::cell_ctrl_t ctrl;

  logic                in_accept;
  logic                gather_en;
  logic                report_en;
  logic                full;
  logic                empty;

  logic [DEPTH-1:0][W-1:0]        data_w;
  logic [NGROUP*GROUP-1:0][W-1:0] leaf_w;
  logic [NGROUP-1:0][W-1:0]       group_w;
  logic [W-1:0]                   back_w;

  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign in_accept = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::S_IDLE:   if (in_accept) state_d = deq_pkg::S_GATHER;
      deq_pkg::S_GATHER: state_d = deq_pkg::S_REPORT;
      deq_pkg::S_REPORT: if (report_en) state_d = deq_pkg::S_IDLE;
      default:           state_d = deq_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    gather_en  = 1'b0;
    report_en  = 1'b0;
    unique case (state_q)
      deq_pkg::S_IDLE:   in_stall_o = 1'b0;
      deq_pkg::S_GATHER: gather_en = 1'b1;
      deq_pkg::S_REPORT: report_en = !out_valid_q || !out_stall_i;
      default:           in_stall_o = 1'b1;
    endcase
  end

  // decode the action into a cell command, count update and status
  always_comb begin
    ctrl.op    = deq_pkg::CELL_HOLD;
    ctrl.value = in_data_i.value;
    count_d    = count_q;
    status_d   = status_q;
    if (in_accept) begin
      status_d = deq_pkg::ST_OK;
      unique case (deq_pkg::act_e'(in_data_i.action))
        deq_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            status_d = deq_pkg::ST_OVERFLOW;
          end else begin
            ctrl.op = deq_pkg::CELL_LOAD_BACK;
            count_d = count_q + CNT_W'(1);
          end
        end
        deq_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            status_d = deq_pkg::ST_OVERFLOW;
          end else begin
            ctrl.op = deq_pkg::CELL_SHIFT_UP;
            count_d = count_q + CNT_W'(1);
          end
        end
        deq_pkg::ACT_POP_BACK: begin
          if (empty) begin
            status_d = deq_pkg::ST_UNDERFLOW;
          end else begin
            count_d = count_q - CNT_W'(1);
          end
        end
        deq_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            status_d = deq_pkg::ST_UNDERFLOW;
          end else begin
            ctrl.op = deq_pkg::CELL_SHIFT_DOWN;
            count_d = count_q - CNT_W'(1);
          end
        end
        default: status_d = deq_pkg::ST_OK;
      endcase
    end
  end

  // row of cells, front element in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] prev_w;
    logic [W-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = in_data_i.value;
    end else begin : g_mid
      assign prev_w = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = data_w[i];
    end else begin : g_inner
      assign next_w = data_w[i+1];
    end
    deq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .data_o  (data_w[i]),
      .back_o  (leaf_w[i])
    );
  end

  // pad the leaf row up to whole groups
  for (genvar p = DEPTH; p < NGROUP * GROUP; p++) begin : g_pad
    assign leaf_w[p] = '0;
  end

  // first level: one register per group of cells
  for (genvar g = 0; g < NGROUP; g++) begin : g_group
    deq_or_reduce #(
      .N (GROUP)
    ) u_group (
      .clk_i    (clk_i),
      .en_i     (gather_en),
      .leaves_i (leaf_w[g*GROUP +: GROUP]),
      .sum_o    (group_w[g])
    );
  end

  // second level: back element, loaded with the result
  deq_or_reduce #(
    .N (NGROUP)
  ) u_root (
    .clk_i    (clk_i),
    .en_i     (report_en),
    .leaves_i (group_w),
    .sum_o    (back_w)
  );

  // hold result valid until the transfer completes
  always_comb begin
    if (report_en) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::S_IDLE;
      count_q     <= '0;
      status_q    <= deq_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (report_en) begin
      out_q.front_value <= empty ? '0 : data_w[0];
      out_q.back_value  <= '0;
      out_q.is_empty    <= empty;
      out_q.occupancy   <= deq_pkg::OCC_W'(count_q);
      out_q.status      <= status_q;
    end
  end

  always_comb begin
    out_data_o            = out_q;
    out_data_o.back_value = back_w;
  end

  assign out_valid_o = out_valid_q;

endmodule
